@@ rtl/stu_pkg.sv @@
package stu_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS = 16;
   localparam int LEN_BITS = 16;
   localparam int KIND_BITS = 6;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
   localparam int KW_COUNT = 8;
   localparam int KW_TEXT_LEN = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0] char_type;
   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [LINE_BITS-1:0] line_type;
   typedef logic [LEN_BITS-1:0] length_type;
   typedef char_type [KW_MAX_LEN-1:0] prefix_type;

   localparam offset_type OFFSET_MAX = '1;
   localparam line_type LINE_MAX = '1;
   localparam length_type LEN_MAX = '1;

   localparam char_type CHAR_NUL = 8'h00;
   localparam char_type CHAR_TAB = 8'h09;
   localparam char_type CHAR_LF = 8'h0A;
   localparam char_type CHAR_CR = 8'h0D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_QUOTE = 8'h22;

   localparam kind_type KIND_EOF = 6'd8;
   localparam kind_type KIND_IDENT = 6'd9;
   localparam kind_type KIND_INT = 6'd10;
   localparam kind_type KIND_STRING = 6'd11;
   localparam kind_type KIND_ASSIGN = 6'd12;
   localparam kind_type KIND_EQ = 6'd13;
   localparam kind_type KIND_NOT = 6'd14;
   localparam kind_type KIND_NE = 6'd15;
   localparam kind_type KIND_LT = 6'd16;
   localparam kind_type KIND_LE = 6'd17;
   localparam kind_type KIND_GT = 6'd18;
   localparam kind_type KIND_GE = 6'd19;
   localparam kind_type KIND_AND = 6'd20;
   localparam kind_type KIND_OR = 6'd21;
   localparam kind_type KIND_STAR = 6'd22;
   localparam kind_type KIND_POWER = 6'd23;
   localparam kind_type KIND_PLUS = 6'd24;
   localparam kind_type KIND_INCR = 6'd25;
   localparam kind_type KIND_MINUS = 6'd26;
   localparam kind_type KIND_DECR = 6'd27;
   localparam kind_type KIND_SLASH = 6'd28;
   localparam kind_type KIND_PERCENT = 6'd29;
   localparam kind_type KIND_COMMA = 6'd30;
   localparam kind_type KIND_SEMI = 6'd31;
   localparam kind_type KIND_COLON = 6'd32;
   localparam kind_type KIND_LPAREN = 6'd33;
   localparam kind_type KIND_RPAREN = 6'd34;
   localparam kind_type KIND_LBRACE = 6'd35;
   localparam kind_type KIND_RBRACE = 6'd36;
   localparam kind_type KIND_LBRACK = 6'd37;
   localparam kind_type KIND_RBRACK = 6'd38;
   localparam kind_type KIND_ILLEGAL = 6'd39;

   localparam char_type KW_CHARS [KW_COUNT][KW_TEXT_LEN] = '{
      '{"i", "f", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "n", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"v", "a", "r", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"t", "r", "u", "e", CHAR_NUL, CHAR_NUL},
      '{"f", "a", "l", "s", "e", CHAR_NUL},
      '{"e", "l", "s", "e", CHAR_NUL, CHAR_NUL},
      '{"w", "h", "i", "l", "e", CHAR_NUL},
      '{"r", "e", "t", "u", "r", "n"}
   };
   localparam int KW_LEN [KW_COUNT] = '{2, 2, 3, 4, 5, 4, 5, 6};

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_STRING,
      MODE_OPER
   } mode_type;

   typedef struct packed {
      kind_type kind;
      line_type line;
      offset_type start;
      length_type length;
      logic last;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type slot0;
      tok_type slot1;
   } push_type;

   function automatic logic alpha_byte(char_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic digit_byte(char_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic blank_byte(char_type c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
   endfunction

   function automatic logic may_pair(char_type c);
      return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
             c == "|" || c == "*" || c == "+" || c == "-";
   endfunction

   function automatic char_type pair_second(char_type c);
      if (c == "=" || c == "!" || c == "<" || c == ">") begin
         return "=";
      end
      return c;
   endfunction

   function automatic kind_type single_kind(char_type c);
      kind_type k;
      case (c)
         "=": k = KIND_ASSIGN;
         "!": k = KIND_NOT;
         "<": k = KIND_LT;
         ">": k = KIND_GT;
         "*": k = KIND_STAR;
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "/": k = KIND_SLASH;
         "%": k = KIND_PERCENT;
         ",": k = KIND_COMMA;
         ";": k = KIND_SEMI;
         ":": k = KIND_COLON;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         "[": k = KIND_LBRACK;
         "]": k = KIND_RBRACK;
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic kind_type pair_kind(char_type c);
      kind_type k;
      case (c)
         "=": k = KIND_EQ;
         "!": k = KIND_NE;
         "<": k = KIND_LE;
         ">": k = KIND_GE;
         "&": k = KIND_AND;
         "|": k = KIND_OR;
         "*": k = KIND_POWER;
         "+": k = KIND_INCR;
         "-": k = KIND_DECR;
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic kind_type ident_kind(prefix_type p, length_type len);
      kind_type k;
      logic same;
      k = KIND_IDENT;
      for (int w = 0; w < KW_COUNT; w++) begin
         if (len == length_type'(KW_LEN[w]) && KW_LEN[w] <= KW_MAX_LEN) begin
            same = 1'b1;
            for (int i = 0; i < KW_TEXT_LEN; i++) begin
               if (i < KW_LEN[w] && p[i] != KW_CHARS[w][i]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               k = kind_type'(w);
            end
         end
      end
      return k;
   endfunction

endpackage

@@ rtl/stu_if.sv @@
interface stu_req_if import stu_pkg::*;;
   logic valid;
   logic ready;
   char_type text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface stu_rsp_if import stu_pkg::*;;
   logic valid;
   logic ready;
   kind_type token_kind;
   line_type token_line;
   offset_type token_start;
   length_type token_length;
   logic last_of_run;

   modport source (output valid, output token_kind, output token_line, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_line, input token_start,
                 input token_length, input last_of_run, output ready);
endinterface

@@ rtl/stu_lexer.sv @@
module stu_lexer import stu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  char_type text_byte,
   output push_type push
);

   mode_type   mode_ff, mode_in;
   char_type   pend_ff, pend_in;
   prefix_type prefix_ff, prefix_in;
   offset_type cur_off_ff, cur_off_in;
   line_type   cur_line_ff, cur_line_in;
   offset_type open_start_ff, open_start_in;
   length_type open_len_ff, open_len_in;
   line_type   open_line_ff, open_line_in;

   logic    done;
   logic    first_valid, second_valid;
   tok_type first_tok, second_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= CHAR_NUL;
         cur_off_ff <= '0;
         cur_line_ff <= line_type'(1);
         open_start_ff <= '0;
         open_len_ff <= '0;
         open_line_ff <= line_type'(1);
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         cur_off_ff <= cur_off_in;
         cur_line_ff <= cur_line_in;
         open_start_ff <= open_start_in;
         open_len_ff <= open_len_in;
         open_line_ff <= open_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prefix_ff <= prefix_in;
      end
   end

   // Set when the byte is consumed by the open token and does not start a new one.
   always_comb begin
      case (mode_ff)
         MODE_IDENT:  done = alpha_byte(text_byte) || digit_byte(text_byte);
         MODE_INT:    done = digit_byte(text_byte);
         MODE_STRING: done = text_byte != CHAR_NUL;
         MODE_OPER:   done = text_byte == pair_second(pend_ff);
         default:     done = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      prefix_in = prefix_ff;
      cur_line_in = cur_line_ff;
      open_start_in = open_start_ff;
      open_len_in = open_len_ff;
      open_line_in = open_line_ff;
      cur_off_in = (cur_off_ff == OFFSET_MAX) ? cur_off_ff : cur_off_ff + 1'b1;

      case (mode_ff)
         MODE_IDENT: begin
            if (done) begin
               if (open_len_ff < length_type'(KW_MAX_LEN)) begin
                  prefix_in[open_len_ff[KW_IDX_BITS-1:0]] = text_byte;
               end
               open_len_in = (open_len_ff == LEN_MAX) ? open_len_ff : open_len_ff + 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_INT: begin
            if (done) begin
               open_len_in = (open_len_ff == LEN_MAX) ? open_len_ff : open_len_ff + 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (text_byte == CHAR_NUL || text_byte == CHAR_QUOTE) begin
               mode_in = MODE_IDLE;
            end else begin
               open_len_in = (open_len_ff == LEN_MAX) ? open_len_ff : open_len_ff + 1'b1;
            end
         end
         MODE_OPER: begin
            mode_in = MODE_IDLE;
            pend_in = CHAR_NUL;
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (text_byte == CHAR_LF) begin
         cur_line_in = (cur_line_ff == LINE_MAX) ? cur_line_ff : cur_line_ff + 1'b1;
      end

      if (!done) begin
         if (text_byte == CHAR_NUL) begin
            mode_in = MODE_IDLE;
            pend_in = CHAR_NUL;
            cur_off_in = '0;
            cur_line_in = line_type'(1);
            open_start_in = '0;
            open_len_in = '0;
            open_line_in = line_type'(1);
         end else if (alpha_byte(text_byte)) begin
            prefix_in[0] = text_byte;
            mode_in = MODE_IDENT;
            open_start_in = cur_off_ff;
            open_len_in = length_type'(1);
            open_line_in = cur_line_ff;
         end else if (digit_byte(text_byte)) begin
            mode_in = MODE_INT;
            open_start_in = cur_off_ff;
            open_len_in = length_type'(1);
            open_line_in = cur_line_ff;
         end else if (text_byte == CHAR_QUOTE) begin
            mode_in = MODE_STRING;
            open_start_in = (cur_off_ff == OFFSET_MAX) ? cur_off_ff : cur_off_ff + 1'b1;
            open_len_in = '0;
            open_line_in = cur_line_ff;
         end else if (may_pair(text_byte)) begin
            mode_in = MODE_OPER;
            pend_in = text_byte;
            open_start_in = cur_off_ff;
            open_len_in = length_type'(1);
            open_line_in = cur_line_ff;
         end
      end
   end

   always_comb begin
      first_tok.line = open_line_ff;
      first_tok.start = open_start_ff;
      first_tok.length = open_len_ff;
      first_tok.last = 1'b0;
      case (mode_ff)
         MODE_IDENT: begin
            first_valid = !done;
            first_tok.kind = ident_kind(prefix_ff, open_len_ff);
         end
         MODE_INT: begin
            first_valid = !done;
            first_tok.kind = KIND_INT;
         end
         MODE_STRING: begin
            first_valid = text_byte == CHAR_NUL || text_byte == CHAR_QUOTE;
            first_tok.kind = KIND_STRING;
         end
         MODE_OPER: begin
            first_valid = 1'b1;
            if (done) begin
               first_tok.kind = pair_kind(pend_ff);
               first_tok.length = length_type'(2);
            end else begin
               first_tok.kind = (pend_ff == "&" || pend_ff == "|") ?
                                KIND_ILLEGAL : single_kind(pend_ff);
               first_tok.length = length_type'(1);
            end
         end
         default: begin
            first_valid = 1'b0;
            first_tok.kind = KIND_ILLEGAL;
         end
      endcase

      second_valid = !done && !blank_byte(text_byte) && !alpha_byte(text_byte) &&
                     !digit_byte(text_byte) && text_byte != CHAR_QUOTE &&
                     !may_pair(text_byte);
      second_tok.kind = (text_byte == CHAR_NUL) ? KIND_EOF : single_kind(text_byte);
      second_tok.line = cur_line_ff;
      second_tok.start = cur_off_ff;
      second_tok.length = (text_byte == CHAR_NUL) ? length_type'(0) : length_type'(1);
      second_tok.last = 1'b1;

      push.slot1 = second_tok;
      if (first_valid) begin
         push.slot0 = first_tok;
         push.slot0.last = !second_valid;
      end else begin
         push.slot0 = second_tok;
      end
      if (!accept) begin
         push.count = 2'd0;
      end else begin
         push.count = {1'b0, first_valid} + {1'b0, second_valid};
      end
   end

endmodule

@@ rtl/stu_out_queue.sv @@
module stu_out_queue import stu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   stu_rsp_if.source rsp_bus
);

   tok_type q_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_BITS-1:0] rd_ff, rd_in;
   logic [QUEUE_IDX_BITS-1:0] wr_ff, wr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_IDX_BITS-1:0] wr_next;
   logic pop;
   tok_type head;

   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign wr_next = wr_ff + 1'b1;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign wr_in = wr_ff + QUEUE_IDX_BITS'(push.count);
   assign count_in = count_ff + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
   assign room = count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.slot1;
      end
   end

   assign head = q_ff[rd_ff];
   assign rsp_bus.valid = count_ff != '0;
   assign rsp_bus.token_kind = head.kind;
   assign rsp_bus.token_line = head.line;
   assign rsp_bus.token_start = head.start;
   assign rsp_bus.token_length = head.length;
   assign rsp_bus.last_of_run = head.last;

endmodule

@@ rtl/source_tokenizer_unit.sv @@
// Streaming tokenizer that takes one source byte per word on req_bus, a zero byte ending
// the text, and returns tokens on rsp_bus with kind, starting line, byte offset and
// length. The scanner state updates in the cycle a byte is accepted, so a byte can be
// taken every cycle while the queue has room; each byte yields zero, one or two tokens,
// which land in a four-word result queue and appear on rsp_bus in order. req_bus.ready
// is high while the queue has two free words, so a run of two-token bytes against a sink
// that takes one word per cycle holds the input back as the queue fills. After the zero byte
// the scanner is back in its reset state and the next byte starts a new text on line one.
module source_tokenizer_unit import stu_pkg::*; (
   input logic clock,
   input logic reset,
   stu_req_if.sink req_bus,
   stu_rsp_if.source rsp_bus
);

   logic     accept;
   logic     room;
   push_type push;

   assign req_bus.ready = room;
   assign accept = req_bus.valid && req_bus.ready;

   stu_lexer u_lexer (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .text_byte(req_bus.text_byte),
      .push(push)
   );

   stu_out_queue u_out_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .rsp_bus(rsp_bus)
   );

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> accept)
      else $error("tokens produced without an accepted word");

   a_pair_last_flags: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (push.slot1.last && !push.slot0.last))
      else $error("wrong last flags on a two-token word");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_bus.ready)
      else $error("input not ready after reset");

   a_eof_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.token_kind == KIND_EOF) |->
         (rsp_bus.last_of_run && rsp_bus.token_length == '0))
      else $error("end-of-text token malformed");

endmodule
